/* rtl/core/bdpa_pkg.sv */
// bdpa_pkg: shared types and constants for the binary delta patch apply block
// no dependencies; used by binary_delta_patch_apply

package bdpa_pkg;

    // one control triple is three 8-byte little-endian sign-magnitude words
    localparam int unsigned CTRL_BYTES = 24;
    localparam int unsigned CTRL_CNT_W = 5;
    localparam int unsigned CTRL_HIST_W = 8 * (CTRL_BYTES - 1);

    // a usable length has a magnitude of at most 31 bits
    localparam int unsigned LEN_W = 31;

    // 32-bit target address and image length fields
    localparam int unsigned TGT_W = 32;

    typedef enum logic [1:0] {
        STATUS_RUN  = 2'd0,
        STATUS_DONE = 2'd1,
        STATUS_FAIL = 2'd2
    } status_t;

endpackage

/* rtl/core/binary_delta_patch_apply.sv */
// binary_delta_patch_apply: streaming apply of a bsdiff style patch, one patch byte per cycle
// while no stalled result is waiting; depends on bdpa_pkg

// Usage
// - input channel (in_valid/in_stall): one decompressed patch byte plus the source
//   byte read at the source_addr of the previous result (at the reset value 0 first)
// - result channel (res_valid/res_stall): exactly one result per input transaction:
//   out_valid/out_byte/target_addr are the target byte to write, source_addr the
//   next source byte to fetch, flush_hint marks an extra byte that ends the image,
//   status is running, done or length failure
// - cfg channel (cfg_valid/cfg_ready/cfg_data): target_length, always ready;
//   write it while the block is idle
// - the result of an accepted transaction is registered and appears in the cycle
//   after; one transaction per cycle is sustained while no result is held, through the
//   single register stage of triple decode, byte add and position update
// - a waiting result holds the result register; in_stall follows res_stall while
//   a result is held, so nothing is lost and the input side resumes at once
// - reset clears all positions, the control collector and target_length; the
//   block starts gathering the first control triple
// - done and failed are sticky until reset; later transactions return
//   out_valid 0 with the status held

module binary_delta_patch_apply #(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  patch_byte,
    input  logic [7:0]  old_byte,

    output logic        res_valid,
    input  logic        res_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic [31:0] target_addr,
    output logic [31:0] source_addr,
    output logic        flush_hint,
    output logic [1:0]  status
);

    localparam int unsigned CntW  = bdpa_pkg::CTRL_CNT_W;
    localparam int unsigned HistW = bdpa_pkg::CTRL_HIST_W;
    localparam int unsigned LenW  = bdpa_pkg::LEN_W;
    localparam int unsigned TgtW  = bdpa_pkg::TGT_W;
    localparam logic [CntW-1:0] CtrlLast = CntW'(bdpa_pkg::CTRL_BYTES - 1);

    typedef enum logic [2:0] {
        PH_CTRL,
        PH_DIFF,
        PH_EXTRA,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic [HistW-1:0]        ctrl_reg, ctrl_next;
    logic [LenW-1:0]         rem_reg, rem_next;
    logic [LenW-1:0]         pend_reg, pend_next;
    logic [63:0]             seek_reg, seek_next;
    logic [TgtW-1:0]         tpos_reg, tpos_next;
    logic [ADDR_WIDTH-1:0]   src_reg, src_next;
    logic [TgtW-1:0]         tlen_reg, tlen_next;

    logic                    res_valid_reg, res_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic [TgtW-1:0]         taddr_reg, taddr_next;
    logic                    flush_reg, flush_next;

    logic                    accept;

    // control triple as it stands with the current byte appended
    logic [HistW+7:0]        full_ctrl;
    logic [63:0]             w0, w1, w2;
    logic                    bad0, bad1;
    logic [LenW-1:0]         mag0, mag1;

    logic [TgtW-1:0]         tpos_plus1;
    logic [TgtW:0]           tpos_inc;
    logic [TgtW:0]           diff_sum;
    logic [TgtW:0]           extra_sum_c;
    logic [TgtW:0]           extra_sum_d;

    logic [63:0]             seek_word;
    logic [ADDR_WIDTH-1:0]   src_base;
    logic [ADDR_WIDTH-1:0]   seek_mag;
    logic [ADDR_WIDTH-1:0]   src_seeked;

    assign cfg_ready = 1'b1;
    assign in_stall  = res_valid_reg && res_stall;
    assign accept    = in_valid && !in_stall;

    assign full_ctrl = {patch_byte, ctrl_reg};
    assign w0 = full_ctrl[63:0];
    assign w1 = full_ctrl[127:64];
    assign w2 = full_ctrl[191:128];

    // negative zero is fine, anything else negative or above 31 bits is not
    assign bad0 = (|w0[62:31]) || (w0[63] && (|w0[30:0]));
    assign bad1 = (|w1[62:31]) || (w1[63] && (|w1[30:0]));
    assign mag0 = w0[LenW-1:0];
    assign mag1 = w1[LenW-1:0];

    assign tpos_plus1  = tpos_reg + TgtW'(1);
    assign tpos_inc    = {1'b0, tpos_reg} + (TgtW+1)'(1);
    assign diff_sum    = {1'b0, tpos_reg} + (TgtW+1)'(mag0);
    assign extra_sum_c = {1'b0, tpos_reg} + (TgtW+1)'(mag1);
    assign extra_sum_d = {1'b0, tpos_plus1} + (TgtW+1)'(pend_reg);

    // the seek comes straight from the triple when both blocks are empty
    assign seek_word  = (phase_reg == PH_CTRL) ? w2 : seek_reg;
    assign src_base   = (phase_reg == PH_DIFF) ? src_reg + ADDR_WIDTH'(1) : src_reg;
    assign seek_mag   = ADDR_WIDTH'(seek_word[62:0]);
    assign src_seeked = seek_word[63] ? src_base - seek_mag : src_base + seek_mag;

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ctrl_next      = ctrl_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        seek_next      = seek_reg;
        tpos_next      = tpos_reg;
        src_next       = src_reg;
        tlen_next      = tlen_reg;
        res_valid_next = res_valid_reg && res_stall;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        taddr_next     = taddr_reg;
        flush_next     = flush_reg;

        if (cfg_valid && cfg_ready)
        begin
            tlen_next = cfg_data;
        end

        if (accept)
        begin
            res_valid_next = 1'b1;
            out_valid_next = 1'b0;
            out_byte_next  = 8'd0;
            taddr_next     = tpos_reg;
            flush_next     = 1'b0;

            unique case (phase_reg)
                PH_CTRL:
                begin
                    if (cnt_reg == '0 && tpos_reg >= tlen_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        ctrl_next = {patch_byte, ctrl_reg[HistW-1:8]};
                        cnt_next  = cnt_reg + CntW'(1);
                        if (cnt_reg == CtrlLast)
                        begin
                            cnt_next = '0;
                            if (bad0 || bad1 || diff_sum > {1'b0, tlen_reg})
                            begin
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                pend_next = mag1;
                                seek_next = w2;
                                rem_next  = mag0;
                                if (mag0 != '0)
                                begin
                                    phase_next = PH_DIFF;
                                end
                                else if (extra_sum_c > {1'b0, tlen_reg})
                                begin
                                    phase_next = PH_FAIL;
                                end
                                else if (mag1 != '0)
                                begin
                                    rem_next   = mag1;
                                    phase_next = PH_EXTRA;
                                end
                                else
                                begin
                                    src_next   = src_seeked;
                                    phase_next = (tpos_reg >= tlen_reg) ? PH_DONE : PH_CTRL;
                                end
                            end
                        end
                    end
                end
                PH_DIFF:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = patch_byte + old_byte;
                    tpos_next      = tpos_plus1;
                    src_next       = src_reg + ADDR_WIDTH'(1);
                    rem_next       = rem_reg - LenW'(1);
                    if (rem_reg == LenW'(1))
                    begin
                        if (extra_sum_d > {1'b0, tlen_reg})
                        begin
                            phase_next = PH_FAIL;
                        end
                        else if (pend_reg != '0)
                        begin
                            rem_next   = pend_reg;
                            phase_next = PH_EXTRA;
                        end
                        else
                        begin
                            src_next   = src_seeked;
                            phase_next = (tpos_plus1 >= tlen_reg) ? PH_DONE : PH_CTRL;
                        end
                    end
                end
                PH_EXTRA:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = patch_byte;
                    flush_next     = (tpos_inc == {1'b0, tlen_reg});
                    tpos_next      = tpos_plus1;
                    rem_next       = rem_reg - LenW'(1);
                    if (rem_reg == LenW'(1))
                    begin
                        src_next   = src_seeked;
                        phase_next = (tpos_plus1 >= tlen_reg) ? PH_DONE : PH_CTRL;
                    end
                end
                PH_DONE, PH_FAIL:
                begin
                    // sticky, transaction is only answered
                end
                default:
                begin
                    phase_next = PH_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CTRL;
            cnt_reg       <= '0;
            ctrl_reg      <= '0;
            rem_reg       <= '0;
            pend_reg      <= '0;
            seek_reg      <= '0;
            tpos_reg      <= '0;
            src_reg       <= '0;
            tlen_reg      <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            taddr_reg     <= '0;
            flush_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            ctrl_reg      <= ctrl_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            seek_reg      <= seek_next;
            tpos_reg      <= tpos_next;
            src_reg       <= src_next;
            tlen_reg      <= tlen_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            taddr_reg     <= taddr_next;
            flush_reg     <= flush_next;
        end
    end

    // position and status change only with a new result, so they are read from state
    assign res_valid   = res_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign target_addr = taddr_reg;
    assign source_addr = 32'(src_reg);
    assign flush_hint  = flush_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_DONE: status = bdpa_pkg::STATUS_DONE;
            PH_FAIL: status = bdpa_pkg::STATUS_FAIL;
            default: status = bdpa_pkg::STATUS_RUN;
        endcase
    end

endmodule
